// File: rtl/bcds_pkg.sv
// Shared types, constants and helpers for the binary to BCD digit scanner.
// No dependencies.
package bcds_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_BITS  = 4;
    localparam int COUNT_W     = 4;
    localparam int DIGIT_POS_W = 4;
    localparam int POS_W       = $clog2(MAX_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RECIP_SHIFT = 35;

    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] digit_vec_t;

    typedef struct packed {
        digit_vec_t digits;
        count_t     count;
    } entry_t;

    // Zero counts as one digit, anything above the maximum saturates.
    function automatic count_t eff_count(input count_t raw);
        count_t res;
        res = raw;
        if (raw == '0)
        begin
            res = COUNT_W'(1);
        end
        else if (raw > COUNT_W'(MAX_DIGITS))
        begin
            res = COUNT_W'(MAX_DIGITS);
        end
        return res;
    endfunction

endpackage

// File: rtl/bcds_if.sv
// Valid/ready channel interfaces for the input values and the digit results.
// Depends on bcds_pkg.
interface bcds_in_if;
    import bcds_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bcds_out_if;
    import bcds_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DIGIT_POS_W-1:0] digit_position;
    digit_t                 bcd_digit;
    logic                   last;

    modport source (output valid, output digit_position, output bcd_digit, output last,
                    input ready);
    modport sink   (input valid, input digit_position, input bcd_digit, input last,
                    output ready);
endinterface

// File: rtl/bcds_front.sv
// Front end: accepts values and peels off one decimal digit per cycle, least
// significant first, by reciprocal multiply. Depends on bcds_pkg, bcds_if.
module bcds_front (
    input  logic              clk,
    input  logic              rst_n,
    input  bcds_pkg::count_t  digit_count,
    bcds_in_if.sink           in_ch,
    output logic              push,
    output bcds_pkg::entry_t  push_data,
    input  logic              full
);
    import bcds_pkg::*;

    logic         busy_reg;
    value_t       v_reg;
    count_t       n_reg;
    pos_t         idx_reg;
    digit_vec_t   digits_reg;

    logic [2*VALUE_W-1:0] prod;
    value_t               quot;
    digit_t               rem;
    logic                 last_step;
    logic                 accept;
    count_t               n_eff;

    always_comb
    begin
        prod      = {{VALUE_W{1'b0}}, v_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
        quot      = VALUE_W'(prod >> RECIP_SHIFT);
        rem       = v_reg[DIGIT_BITS-1:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
        last_step = busy_reg && (idx_reg == '0);
        push      = last_step && !full;
        push_data.digits          = digits_reg;
        push_data.digits[idx_reg] = rem;
        push_data.count           = n_reg;
        in_ch.ready = !busy_reg || push;
        accept      = in_ch.valid && in_ch.ready;
        n_eff       = eff_count(digit_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (push)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg   <= in_ch.value;
            n_reg   <= n_eff;
            idx_reg <= POS_W'(n_eff - COUNT_W'(1));
        end
        else if (busy_reg && !last_step)
        begin
            digits_reg[idx_reg] <= rem;
            v_reg               <= quot;
            idx_reg             <= idx_reg - POS_W'(1);
        end
    end

endmodule

// File: rtl/bcds_queue.sv
// Short FIFO of converted items between the front and back ends.
// Depends on bcds_pkg.
module bcds_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bcds_pkg::entry_t push_data,
    output logic             full,
    output logic             avail,
    output bcds_pkg::entry_t pop_data,
    input  logic             pop
);
    import bcds_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail    = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/bcds_back.sv
// Back end: walks a converted item most significant digit first, one result
// per unstalled cycle, into a registered output. Depends on bcds_pkg, bcds_if.
module bcds_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  bcds_pkg::entry_t pop_data,
    output logic             pop,
    bcds_out_if.source       out_ch
);
    import bcds_pkg::*;

    logic                   have_reg;
    pos_t                   pos_reg;
    count_t                 n_reg;
    digit_vec_t             dig_reg;
    logic                   out_valid_reg;
    logic [DIGIT_POS_W-1:0] out_pos_reg;
    digit_t                 out_digit_reg;
    logic                   out_last_reg;

    logic adv;
    logic is_last;

    always_comb
    begin
        adv     = have_reg && (!out_valid_reg || out_ch.ready);
        is_last = (pos_reg == POS_W'(n_reg - COUNT_W'(1)));
        pop     = avail && (!have_reg || (adv && is_last));
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.digit_position = out_pos_reg;
    assign out_ch.bcd_digit      = out_digit_reg;
    assign out_ch.last           = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                have_reg <= 1'b1;
            end
            else if (adv && is_last)
            begin
                have_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pos_reg <= '0;
            n_reg   <= pop_data.count;
            dig_reg <= pop_data.digits;
        end
        else if (adv)
        begin
            pos_reg <= pos_reg + POS_W'(1);
        end

        if (adv)
        begin
            out_pos_reg   <= DIGIT_POS_W'(pos_reg);
            out_digit_reg <= dig_reg[pos_reg];
            out_last_reg  <= is_last;
        end
    end

endmodule

// File: rtl/binary_to_bcd_digit_scan.sv
// Top level of the binary to BCD digit scanner.
// Depends on bcds_pkg, bcds_if, bcds_front, bcds_queue, bcds_back.
//
// Usage:
//   in_ch carries one 32-bit unsigned value per item. out_ch returns one item
//   per kept decimal digit, most significant first: digit_position (0 is the
//   most significant), bcd_digit and last on the units digit.
//   cfg_we/cfg_wdata write digit_count (0 acts as 1, above 10 acts as 10);
//   write it only while the block is idle. Reset value is 3.
// Flow:
//   The front end does one multiply-by-reciprocal step per kept digit and
//   takes a new value only as it pushes its current one to the queue. The
//   back end emits one digit per cycle while out_ch is ready.
// Reset and stalls:
//   Reset empties the front end, the two-entry queue and the output register.
//   When out_ch stalls, the output register holds and the back end keeps its
//   value; the queue absorbs two more converted values, then the front end
//   holds its finished value and in_ch ready stays low.
module binary_to_bcd_digit_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  bcds_pkg::count_t cfg_wdata,
    bcds_in_if.sink          in_ch,
    bcds_out_if.source       out_ch
);
    import bcds_pkg::*;

    count_t digit_count_reg;
    logic   push;
    entry_t push_data;
    logic   full;
    logic   avail;
    entry_t pop_data;
    logic   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            digit_count_reg <= cfg_wdata;
        end
    end

    bcds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_count (digit_count_reg),
        .in_ch       (in_ch),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    bcds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .avail     (avail),
        .pop_data  (pop_data),
        .pop       (pop)
    );

    bcds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

`ifndef SYNTHESIS
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.bcd_digit <= 4'd9 && out_ch.digit_position <= 4'd9))
        else $error("digit or position out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> avail)
        else $error("queue pop while empty");

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last) |=>
            (!out_ch.valid || out_ch.digit_position == $past(out_ch.digit_position) + 4'd1))
        else $error("digit position out of sequence");
`endif

endmodule
